>>> rtl/assert_macros.svh
// Assertion helpers for the RTL. They expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising clock edge while reset is released.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/dbecl_pkg.sv
package dbecl_pkg;

  localparam int ROW_W = 64;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;
  localparam int CFG_W = 7;

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

  localparam logic [LEN_W-1:0] NO_PARENT = 7'h7F;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_DIRECTED     = 1'b1;

endpackage

>>> rtl/dfs_back_edge_cycle_lengths.sv
// Row word: accepted and stored at the accepting edge; busy_o stays low, so one per cycle.
// Last row word: with V = vertex_count capped at MAX_VERTICES, a mark clearing pass and the walk
// then bring the result strobe, with an extra length step per back edge to a vertex on the stack
// and a restore step per return to a parent; busy_o is high meanwhile.
// The receiver cannot stall. Reset clears control and configuration (64 vertices, undirected);
// visit marks are cleared at the start of each walk and stored rows are kept.
`include "assert_macros.svh"

module dfs_back_edge_cycle_lengths #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [dbecl_pkg::IDX_W-1:0]  row_index_i,
  input  logic [dbecl_pkg::ROW_W-1:0]  row_edges_i,
  input  logic                         last_row_i,
  output logic                         done_o,
  output logic                         cycle_found_o,
  output logic [dbecl_pkg::LEN_W-1:0]  smallest_length_o,
  output logic [dbecl_pkg::LEN_W-1:0]  largest_length_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [dbecl_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int LW = dbecl_pkg::LEN_W;
  localparam logic [LW-1:0] MaxV    = LW'(MAX_VERTICES);
  localparam logic [LW-1:0] MinInit = LW'(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_REST = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [LW-1:0] vcount_q;
  logic          directed_q;
  logic [LW-1:0] sp_q, sp_d;
  logic [LW-1:0] root_q, root_d;
  logic [VW-1:0] cur_u_q, cur_u_d;
  logic [LW-1:0] cur_n_q, cur_n_d;
  logic [LW-1:0] cur_par_q, cur_par_d;
  logic [LW-1:0] min_q, min_d;
  logic [LW-1:0] max_q, max_d;
  logic          done_q, done_d;
  logic          found_q, found_d;
  logic [LW-1:0] small_q, small_d;
  logic [LW-1:0] large_q, large_d;
  logic [1:0]    mark_mem [MAX_VERTICES];
  logic [1:0]    mark_rd_q;

  logic [dbecl_pkg::ROW_W-1:0] adj_mem [MAX_VERTICES];
  logic [dbecl_pkg::ROW_W-1:0] adj_rd_q;
  logic [LW-1:0] depth_mem [MAX_VERTICES];
  logic [LW-1:0] depth_rd_q;
  logic [VW-1:0] stk_u_mem [MAX_VERTICES];
  logic [LW-1:0] stk_n_mem [MAX_VERTICES];
  logic [LW-1:0] stk_p_mem [MAX_VERTICES];
  logic [VW-1:0] stk_u_rd_q;
  logic [LW-1:0] stk_n_rd_q;
  logic [LW-1:0] stk_p_rd_q;

  logic          adj_we, adj_re;
  logic [VW-1:0] adj_raddr;
  logic          dep_we;
  logic [VW-1:0] dep_waddr;
  logic [LW-1:0] dep_wdata;
  logic          stk_we, stk_re;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic          mark_we;
  logic [VW-1:0] mark_widx;
  logic [1:0]    mark_wval;
  logic [VW-1:0] mark_raddr;

  logic [LW-1:0] nv;
  logic          accept;
  logic          scan_end;
  logic [VW-1:0] n_idx;
  logic          edge_bit;
  logic          skip_par;
  logic [1:0]    n_mark;
  logic [1:0]    root_mark;
  logic [LW-1:0] cyc_len;

  assign nv        = (vcount_q > MaxV) ? MaxV : vcount_q;
  assign accept    = start_i && (state_q == S_IDLE);
  assign scan_end  = cur_n_q >= nv;
  assign n_idx     = cur_n_q[VW-1:0];
  assign edge_bit  = adj_rd_q[cur_n_q[dbecl_pkg::IDX_W-1:0]];
  assign skip_par  = !directed_q && (cur_n_q == cur_par_q);
  assign n_mark    = mark_rd_q;
  assign root_mark = mark_rd_q;
  assign cyc_len   = sp_q - depth_rd_q;

  // The mark of the vertex looked at in the next cycle is read ahead from the next-state address.
  assign mark_raddr = (state_d == S_ROOT) ? root_d[VW-1:0] : cur_n_d[VW-1:0];

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    root_d    = root_q;
    cur_u_d   = cur_u_q;
    cur_n_d   = cur_n_q;
    cur_par_d = cur_par_q;
    min_d     = min_q;
    max_d     = max_q;
    done_d    = 1'b0;
    found_d   = found_q;
    small_d   = small_q;
    large_d   = large_q;
    adj_we    = 1'b0;
    adj_re    = 1'b0;
    adj_raddr = cur_u_q;
    dep_we    = 1'b0;
    dep_waddr = n_idx;
    dep_wdata = sp_q;
    stk_we    = 1'b0;
    stk_waddr = VW'(sp_q - LW'(1));
    stk_re    = 1'b0;
    stk_raddr = VW'(sp_q - LW'(2));
    mark_we   = 1'b0;
    mark_widx = n_idx;
    mark_wval = dbecl_pkg::MARK_OPEN;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          adj_we = {1'b0, row_index_i} < MaxV;
          if (last_row_i) begin
            root_d  = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (root_q < nv) begin
          mark_we   = 1'b1;
          mark_widx = root_q[VW-1:0];
          mark_wval = dbecl_pkg::MARK_FREE;
          root_d    = root_q + LW'(1);
        end else begin
          min_d   = MinInit;
          max_d   = '0;
          sp_d    = '0;
          root_d  = '0;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_q >= nv) begin
          done_d  = 1'b1;
          found_d = max_q != '0;
          small_d = (max_q != '0) ? min_q : '0;
          large_d = max_q;
          state_d = S_IDLE;
        end else begin
          root_d = root_q + LW'(1);
          if (root_mark == dbecl_pkg::MARK_FREE) begin
            mark_we   = 1'b1;
            mark_widx = root_q[VW-1:0];
            dep_we    = 1'b1;
            dep_waddr = root_q[VW-1:0];
            dep_wdata = '0;
            adj_re    = 1'b1;
            adj_raddr = root_q[VW-1:0];
            cur_u_d   = root_q[VW-1:0];
            cur_n_d   = '0;
            cur_par_d = dbecl_pkg::NO_PARENT;
            sp_d      = LW'(1);
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          mark_we   = 1'b1;
          mark_widx = cur_u_q;
          mark_wval = dbecl_pkg::MARK_DONE;
          sp_d      = sp_q - LW'(1);
          if (sp_q == LW'(1)) begin
            state_d = S_ROOT;
          end else begin
            stk_re  = 1'b1;
            state_d = S_REST;
          end
        end else begin
          cur_n_d = cur_n_q + LW'(1);
          if (edge_bit && !skip_par) begin
            if (n_mark == dbecl_pkg::MARK_FREE) begin
              stk_we    = 1'b1;
              mark_we   = 1'b1;
              dep_we    = 1'b1;
              adj_re    = 1'b1;
              adj_raddr = n_idx;
              cur_u_d   = n_idx;
              cur_n_d   = '0;
              cur_par_d = LW'(cur_u_q);
              sp_d      = sp_q + LW'(1);
            end else if (n_mark == dbecl_pkg::MARK_OPEN) begin
              state_d = S_LEN;
            end
          end
        end
      end
      S_LEN: begin
        if (cyc_len > LW'(1)) begin
          if (cyc_len < min_q) begin
            min_d = cyc_len;
          end
          if (cyc_len > max_q) begin
            max_d = cyc_len;
          end
        end
        state_d = S_SCAN;
      end
      S_REST: begin
        cur_u_d   = stk_u_rd_q;
        cur_n_d   = stk_n_rd_q;
        cur_par_d = stk_p_rd_q;
        adj_re    = 1'b1;
        adj_raddr = stk_u_rd_q;
        state_d   = S_SCAN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vcount_q   <= 7'd64;
      directed_q <= 1'b0;
      sp_q       <= '0;
      root_q     <= '0;
      min_q      <= MinInit;
      max_q      <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      small_q    <= '0;
      large_q    <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      root_q  <= root_d;
      min_q   <= min_d;
      max_q   <= max_d;
      done_q  <= done_d;
      found_q <= found_d;
      small_q <= small_d;
      large_q <= large_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dbecl_pkg::CFG_VERTEX_COUNT: vcount_q   <= cfg_data_i;
          dbecl_pkg::CFG_DIRECTED:     directed_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_u_q   <= cur_u_d;
    cur_n_q   <= cur_n_d;
    cur_par_q <= cur_par_d;
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_widx] <= mark_wval;
    end
    if (mark_we && (mark_widx == mark_raddr)) begin
      mark_rd_q <= mark_wval;
    end else begin
      mark_rd_q <= mark_mem[mark_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[row_index_i[VW-1:0]] <= row_edges_i;
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      depth_mem[dep_waddr] <= dep_wdata;
    end
    depth_rd_q <= depth_mem[n_idx];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_u_mem[stk_waddr] <= cur_u_q;
      stk_n_mem[stk_waddr] <= cur_n_q + LW'(1);
      stk_p_mem[stk_waddr] <= cur_par_q;
    end
    if (stk_re) begin
      stk_u_rd_q <= stk_u_mem[stk_raddr];
      stk_n_rd_q <= stk_n_mem[stk_raddr];
      stk_p_rd_q <= stk_p_mem[stk_raddr];
    end
  end

  assign busy_o            = state_q != S_IDLE;
  assign done_o            = done_q;
  assign cycle_found_o     = found_q;
  assign smallest_length_o = small_q;
  assign largest_length_o  = large_q;

  `ASSERT_RST(a_done_single, done_o |=> !done_o, "result strobe lasted more than one cycle")
  `ASSERT_RST(a_done_idle, done_o |-> !busy_o, "result strobe while the walk is still running")
  `ASSERT_RST(a_sp_bound, sp_q <= MaxV, "stack pointer beyond the vertex limit")
  `ASSERT_RST(a_scan_stack, (state_q == S_SCAN) |-> (sp_q != '0),
              "neighbor scan with an empty stack")
  `ASSERT_RST(a_lengths, (done_o && cycle_found_o) |->
              (smallest_length_o > LW'(1) && smallest_length_o <= largest_length_o),
              "reported cycle lengths are inconsistent")

endmodule
